// File: design/aes_rou_pkg.sv
package aes_rou_pkg;

  // Opcodes carried in the op field of a request item
  localparam logic [3:0] OP_LOAD     = 4'd0;
  localparam logic [3:0] OP_ADD_KEY  = 4'd1;
  localparam logic [3:0] OP_SUB      = 4'd2;
  localparam logic [3:0] OP_INV_SUB  = 4'd3;
  localparam logic [3:0] OP_SHIFT    = 4'd4;
  localparam logic [3:0] OP_INV_SHFT = 4'd5;
  localparam logic [3:0] OP_MIX      = 4'd6;
  localparam logic [3:0] OP_INV_MIX  = 4'd7;
  localparam logic [3:0] OP_READ     = 4'd8;

  localparam int NumBytes = 16;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
  } req_t;

  typedef struct packed {
    logic [63:0] state_hi;
    logic [63:0] state_lo;
  } rsp_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // Multiply by x in GF(2^8), reduction polynomial 0x11B
  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// File: design/aes_rou_xform.sv
// One AES round transformation on the 128-bit state, byte 0 in bits 127:120.
module aes_rou_xform (
  input  logic [3:0]   op,
  input  logic [63:0]  data_hi,
  input  logic [63:0]  data_lo,
  input  logic [127:0] state,
  output logic [127:0] state_next
);
  import aes_rou_pkg::*;

  logic [7:0] cur   [NumBytes];
  logic [7:0] dat   [NumBytes];
  logic [7:0] sub   [NumBytes];
  logic [7:0] isub  [NumBytes];
  logic [7:0] shf   [NumBytes];
  logic [7:0] ishf  [NumBytes];
  logic [7:0] x2    [NumBytes];
  logic [7:0] x4    [NumBytes];
  logic [7:0] x8    [NumBytes];
  logic [7:0] mix   [NumBytes];
  logic [7:0] imix  [NumBytes];
  logic [127:0] data_all;
  logic [127:0] sub_all;
  logic [127:0] isub_all;
  logic [127:0] shf_all;
  logic [127:0] ishf_all;
  logic [127:0] mix_all;
  logic [127:0] imix_all;

  assign data_all = {data_hi, data_lo};

  always_comb begin
    for (int i = 0; i < NumBytes; i++) begin
      cur[i]  = state[127 - 8*i -: 8];
      dat[i]  = data_all[127 - 8*i -: 8];
      sub[i]  = SBOX[cur[i]];
      isub[i] = INV_SBOX[cur[i]];
      x2[i]   = xtime(cur[i]);
      x4[i]   = xtime(x2[i]);
      x8[i]   = xtime(x4[i]);
    end
  end

  // Byte r of column c comes from column c+r (forward) or c-r (inverse)
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shf[r + 4*c]  = cur[r + 4*((c + r) & 3)];
        ishf[r + 4*c] = cur[r + 4*((c + 4 - r) & 3)];
      end
    end
  end

  // Coefficient of input row k for output row r is row0[(k - r) mod 4]
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mix[r + 4*c]  = 8'h00;
        imix[r + 4*c] = 8'h00;
        for (int k = 0; k < 4; k++) begin
          case ((k + 4 - r) & 3)
            0: begin
              mix[r + 4*c]  = mix[r + 4*c] ^ x2[k + 4*c];
              imix[r + 4*c] = imix[r + 4*c] ^ x8[k + 4*c] ^ x4[k + 4*c] ^ x2[k + 4*c];
            end
            1: begin
              mix[r + 4*c]  = mix[r + 4*c] ^ x2[k + 4*c] ^ cur[k + 4*c];
              imix[r + 4*c] = imix[r + 4*c] ^ x8[k + 4*c] ^ x2[k + 4*c] ^ cur[k + 4*c];
            end
            2: begin
              mix[r + 4*c]  = mix[r + 4*c] ^ cur[k + 4*c];
              imix[r + 4*c] = imix[r + 4*c] ^ x8[k + 4*c] ^ x4[k + 4*c] ^ cur[k + 4*c];
            end
            default: begin
              mix[r + 4*c]  = mix[r + 4*c] ^ cur[k + 4*c];
              imix[r + 4*c] = imix[r + 4*c] ^ x8[k + 4*c] ^ cur[k + 4*c];
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumBytes; i++) begin
      sub_all[127 - 8*i -: 8]  = sub[i];
      isub_all[127 - 8*i -: 8] = isub[i];
      shf_all[127 - 8*i -: 8]  = shf[i];
      ishf_all[127 - 8*i -: 8] = ishf[i];
      mix_all[127 - 8*i -: 8]  = mix[i];
      imix_all[127 - 8*i -: 8] = imix[i];
    end
  end

  always_comb begin
    unique case (op)
      OP_LOAD:     state_next = data_all;
      OP_ADD_KEY:  state_next = state ^ data_all;
      OP_SUB:      state_next = sub_all;
      OP_INV_SUB:  state_next = isub_all;
      OP_SHIFT:    state_next = shf_all;
      OP_INV_SHFT: state_next = ishf_all;
      OP_MIX:      state_next = mix_all;
      OP_INV_MIX:  state_next = imix_all;
      OP_READ:     state_next = state;
      default:     state_next = state;
    endcase
  end

endmodule

// File: design/aes_round_operation_unit.sv
// A request item goes through the input stage register, then updates the state and
//   the response register together once the response register can take it.
// Throughput: one item per cycle unless responses stall; state loops via u_xform.
// Reset (rst, synchronous, active high): cipher state cleared to zero, both
//   the input stage and the response register emptied.
module aes_round_operation_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  aes_rou_pkg::req_t   req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output aes_rou_pkg::rsp_t   rsp
);
  import aes_rou_pkg::*;

  // Input stage: holds one accepted item until it can be applied
  logic         stage_valid;
  req_t         stage;

  // Cipher state, 16 bytes column-major, byte 0 in bits 127:120
  logic [127:0] state;
  logic [127:0] state_next;

  // The staged item is applied when the response register is empty or
  // being drained this cycle. The state only moves on that edge, so items
  // are applied strictly in arrival order.
  logic         advance;

  assign advance   = stage_valid && (!rsp_valid || rsp_ready);
  // Stage can refill in the same cycle it hands its item on.
  assign req_ready = !stage_valid || advance;

  aes_rou_xform u_xform (
    .op         (stage.op),
    .data_hi    (stage.data_hi),
    .data_lo    (stage.data_lo),
    .state      (state),
    .state_next (state_next)
  );

  // Control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      rsp_valid   <= 1'b0;
      state       <= '0;
    end else begin
      if (req_ready) begin
        stage_valid <= req_valid;
      end
      if (advance) begin
        state     <= state_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stage <= req;
    end
    if (advance) begin
      rsp.state_hi <= state_next[127:64];
      rsp.state_lo <= state_next[63:0];
    end
  end

endmodule

// File: design/aes_rou_checker.sv
module aes_rou_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input aes_rou_pkg::rsp_t rsp
);
  import aes_rou_pkg::*;

  // Items accepted but not yet delivered
  logic [1:0] inflight;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 2'd0;
    end else begin
      inflight <= inflight + {1'b0, req_fire} - {1'b0, rsp_fire};
    end
  end

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Reset empties the response register
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // At most two items in flight, and no response without an item behind it
  a_inflight: assert property (@(posedge clk) disable iff (rst)
    (inflight != 2'd3) && (!rsp_valid || inflight != 2'd0))
    else $error("item count out of range");

  // Requests are only back-pressured by a stalled response
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request stalled without response back-pressure");

endmodule

bind aes_round_operation_unit aes_rou_checker u_chk (.*);

// File: test/testbench.sv
module testbench;
  import aes_rou_pkg::*;

  localparam int StallLimit = 2000;   // cycles with no item moving on either side
  localparam int IdlePct    = 12;     // idle chance per cycle, each side
  localparam int CalmFrom   = 300;    // cycle window with no idling at all
  localparam int CalmTo     = 800;
  localparam int RandItems  = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  aes_round_operation_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: private copy of the 16 state bytes, column-major
  // (byte i = row i%4 of column i/4). S-box tables are derived here from the
  // field inverse plus affine map, not taken from the package.
  // ---------------------------------------------------------------------------
  logic [7:0] cipher_bytes [NumBytes];
  logic [7:0] sub_lut      [256];
  logic [7:0] inv_sub_lut  [256];

  function automatic logic [7:0] gf_mult(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // a^254 gives the multiplicative inverse; zero stays zero
  function automatic logic [7:0] gf_recip(logic [7:0] a);
    logic [7:0] r;
    r = 8'h01;
    for (int k = 0; k < 254; k++) r = gf_mult(r, a);
    return r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic void build_sbox_tables();
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      b = gf_recip(x[7:0]);
      sub_lut[x] = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
      b = rol8(x[7:0], 1) ^ rol8(x[7:0], 3) ^ rol8(x[7:0], 6) ^ 8'h05;
      inv_sub_lut[x] = gf_recip(b);
    end
  endfunction

  // One column mix; coefficient row 0 rotates right by one per output row
  function automatic void mix_columns(logic [7:0] c0, logic [7:0] c1,
                                      logic [7:0] c2, logic [7:0] c3);
    logic [7:0] coef [4];
    logic [7:0] col  [4];
    coef = '{c0, c1, c2, c3};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        col[r] = '0;
        for (int k = 0; k < 4; k++)
          col[r] ^= gf_mult(coef[(k + 4 - r) % 4], cipher_bytes[k + 4 * c]);
      end
      for (int r = 0; r < 4; r++) cipher_bytes[r + 4 * c] = col[r];
    end
  endfunction

  function automatic void shift_rows(bit backward);
    logic [7:0] t [NumBytes];
    int src;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        src = backward ? (c + 4 - r) % 4 : (c + r) % 4;
        t[r + 4 * c] = cipher_bytes[r + 4 * src];
      end
    cipher_bytes = t;
  endfunction

  // Apply one item to the predicted state, return the state it should report
  function automatic rsp_t advance_state(req_t item);
    logic [127:0] din;
    rsp_t         res;
    din = {item.data_hi, item.data_lo};
    case (item.op)
      OP_LOAD:     for (int i = 0; i < NumBytes; i++) cipher_bytes[i] = din[127 - 8 * i -: 8];
      OP_ADD_KEY:  for (int i = 0; i < NumBytes; i++) cipher_bytes[i] ^= din[127 - 8 * i -: 8];
      OP_SUB:      for (int i = 0; i < NumBytes; i++) cipher_bytes[i] = sub_lut[cipher_bytes[i]];
      OP_INV_SUB:  for (int i = 0; i < NumBytes; i++)
                     cipher_bytes[i] = inv_sub_lut[cipher_bytes[i]];
      OP_SHIFT:    shift_rows(1'b0);
      OP_INV_SHFT: shift_rows(1'b1);
      OP_MIX:      mix_columns(8'd2, 8'd3, 8'd1, 8'd1);
      OP_INV_MIX:  mix_columns(8'd14, 8'd11, 8'd13, 8'd9);
      default: ;   // read and unused opcodes leave the state alone
    endcase
    for (int i = 0; i < NumBytes; i++) din[127 - 8 * i -: 8] = cipher_bytes[i];
    res.state_hi = din[127:64];
    res.state_lo = din[63:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: request items come from pending_items; valid holds until taken.
  // The expected state is computed at the edge where the item is accepted.
  // ---------------------------------------------------------------------------
  req_t pending_items [$];
  rsp_t state_expect_q [$];
  int   cycle_cnt = 0;
  int   mismatch_cnt = 0;

  function automatic bit idle_now();
    if (cycle_cnt >= CalmFrom && cycle_cnt < CalmTo) return 1'b0;
    return $urandom_range(99) < IdlePct;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst) begin
      req_valid <= 1'b0;
      // predicted state follows the block's reset: all bytes zero
      for (int i = 0; i < NumBytes; i++) cipher_bytes[i] = '0;
    end else begin
      if (req_valid && req_ready) state_expect_q.push_back(advance_state(req));
      // slot is free once the held item is taken (or nothing was held)
      if (!req_valid || req_ready) begin
        if (pending_items.size() != 0 && !idle_now()) begin
          req       <= pending_items.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, compare each response with the oldest
  // expected state, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !idle_now();
      if (rsp_valid && rsp_ready) begin
        if (state_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected response: state_hi %h state_lo %h",
                     rsp.state_hi, rsp.state_lo);
        end else begin
          want = state_expect_q.pop_front();
          if (rsp.state_hi !== want.state_hi) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("state_hi mismatch: expected %h actual %h", want.state_hi,
                       rsp.state_hi);
          end
          if (rsp.state_lo !== want.state_lo) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("state_lo mismatch: expected %h actual %h", want.state_lo,
                       rsp.state_lo);
          end
        end
      end
    end
  end

  // Watchdog: no item moving on either channel for too long
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt + 1 >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void queue_item(logic [3:0] op, logic [63:0] hi, logic [63:0] lo);
    req_t item;
    item.op      = op;
    item.data_hi = hi;
    item.data_lo = lo;
    pending_items.push_back(item);
  endfunction

  // any opcode, with the rare unused ones included
  function automatic void queue_single_op();
    int pick;
    logic [3:0] op;
    pick = $urandom_range(99);
    if (pick < 10)      op = OP_LOAD;
    else if (pick < 16) op = 4'($urandom_range(15, OP_READ + 1));
    else                op = 4'($urandom_range(OP_READ, OP_ADD_KEY));
    queue_item(op, rand64(), rand64());
  endfunction

  initial begin
    int n;
    build_sbox_tables();

    // Directed part
    queue_item(OP_READ, '0, '0);                                  // reset state is zero
    queue_item(OP_LOAD, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_item(OP_ADD_KEY, 64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    queue_item(OP_SUB, rand64(), rand64());                       // data ignored
    queue_item(OP_SHIFT, rand64(), rand64());
    queue_item(OP_MIX, rand64(), rand64());
    queue_item(OP_ADD_KEY, rand64(), rand64());
    queue_item(OP_INV_MIX, rand64(), rand64());
    queue_item(OP_INV_SHFT, rand64(), rand64());
    queue_item(OP_INV_SUB, rand64(), rand64());
    queue_item(OP_LOAD, '1, '1);
    queue_item(OP_SUB, '0, '0);
    queue_item(OP_INV_SUB, '1, '1);
    queue_item(OP_LOAD, '0, '0);
    queue_item(OP_SUB, '0, '0);                                   // zero through the S-box
    queue_item(OP_INV_SUB, '0, '0);
    queue_item(OP_INV_SUB, '0, '0);                               // zero through inverse
    queue_item(OP_ADD_KEY, '1, '1);
    queue_item(OP_MIX, '1, '1);
    for (int op = OP_READ + 1; op < 16; op++)                     // unused opcodes read back
      queue_item(op[3:0], rand64(), rand64());

    // Random part: mostly whole rounds on a live state, plus single ops
    n = 0;
    while (n < RandItems) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          queue_item(OP_SUB, rand64(), rand64());
          queue_item(OP_SHIFT, rand64(), rand64());
          queue_item(OP_MIX, rand64(), rand64());
          queue_item(OP_ADD_KEY, rand64(), rand64());
          n += 4;
        end
        3, 4, 5: begin
          queue_item(OP_ADD_KEY, rand64(), rand64());
          queue_item(OP_INV_MIX, rand64(), rand64());
          queue_item(OP_INV_SHFT, rand64(), rand64());
          queue_item(OP_INV_SUB, rand64(), rand64());
          n += 4;
        end
        default: begin
          queue_single_op();
          n++;
        end
      endcase
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // drain: everything sent and every response seen
    do @(posedge clk);
    while (pending_items.size() != 0 || req_valid || state_expect_q.size() != 0);
    repeat (8) @(posedge clk);   // catch any stray response after the last one

    if (mismatch_cnt == 0 && state_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
